/* hdl/dps_pkg.sv */
// package: queue sizing, item and entry types, status codes, controller states
`timescale 1ns / 1ps
package dps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = 24;

  typedef enum logic [0:0] {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_ZERO_RUN = 3'd2,
    ST_REQUEUED = 3'd3,
    ST_FINISHED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    req_t              req_type;
    logic [7:0]        task_id;
    logic [7:0]        run_time;
    logic signed [7:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] ran_id;
    logic [4:0] queue_count;
  } out_item_t;

  // one ready queue slot: priority on top, then remaining ticks, then id
  typedef struct packed {
    logic signed [7:0] prio;
    logic [7:0]        rem;
    logic [7:0]        id;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_PLACE,
    S_RESP
  } state_t;

  // circular buffer slot of a position counted from the head
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hdl/dps_ram.sv */
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
module dps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/dps_ctrl.sv */
// queue controller: head pop and tail-to-head insertion walk over the ram
`timescale 1ns / 1ps
module dps_ctrl
  import dps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_data
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  entry_t            new_r, new_nxt;
  status_t           status_r, status_nxt;
  logic [7:0]        ran_r, ran_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;

  logic              accept;
  logic [7:0]        head_rem_dec;
  logic signed [7:0] head_prio_dec;
  logic [CNT_W-1:0]  cnt_dec;
  logic              walk_stop;

  dps_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept        = in_valid && in_ready;
  assign head_rem_dec  = mem_rdata.rem - 8'd1;
  // priority saturates at its minimum
  assign head_prio_dec = (mem_rdata.prio == 8'sh80) ? mem_rdata.prio
                                                    : mem_rdata.prio - 8'sd1;
  assign cnt_dec       = count_r - 1'b1;
  assign walk_stop     = $signed(mem_rdata.prio) >= $signed(new_r.prio);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ADD) begin
            if (in_data.run_time == 8'd0 || count_r == CNT_W'(QUEUE_DEPTH) ||
                count_r == '0) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (count_r == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (head_rem_dec == 8'd0 || cnt_dec == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          state_nxt = S_RESP;
        end else if (k_r == '0) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs, ram port and datapath
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    res_valid  = (state_r == S_RESP);
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = new_r;
    mem_raddr  = head_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    new_nxt    = new_r;
    status_nxt = status_r;
    ran_nxt    = ran_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ran_nxt = 8'd0;
          if (in_data.req_type == REQ_ADD) begin
            new_nxt.prio = in_data.priority_req;
            new_nxt.rem  = in_data.run_time;
            new_nxt.id   = in_data.task_id;
            if (in_data.run_time == 8'd0) begin
              status_nxt = ST_ZERO_RUN;
            end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              status_nxt = ST_FULL;
            end else if (count_r == '0) begin
              status_nxt   = ST_ADDED;
              mem_we       = 1'b1;
              mem_waddr    = head_r;
              mem_wdata.prio = in_data.priority_req;
              mem_wdata.rem  = in_data.run_time;
              mem_wdata.id   = in_data.task_id;
              count_nxt    = count_r + 1'b1;
            end else begin
              status_nxt = ST_ADDED;
              k_nxt      = IDX_W'(cnt_dec);
              mem_raddr  = phys_idx(head_r, IDX_W'(cnt_dec));
            end
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            mem_raddr = head_r;
          end
        end
      end
      S_HEAD: begin
        ran_nxt   = mem_rdata.id;
        head_nxt  = phys_idx(head_r, IDX_W'(1));
        count_nxt = cnt_dec;
        if (head_rem_dec == 8'd0) begin
          status_nxt = ST_FINISHED;
        end else begin
          status_nxt   = ST_REQUEUED;
          new_nxt.prio = head_prio_dec;
          new_nxt.rem  = head_rem_dec;
          new_nxt.id   = mem_rdata.id;
          if (cnt_dec == '0) begin
            mem_we         = 1'b1;
            mem_waddr      = head_nxt;
            mem_wdata.prio = head_prio_dec;
            mem_wdata.rem  = head_rem_dec;
            mem_wdata.id   = mem_rdata.id;
            count_nxt      = count_r;
          end else begin
            k_nxt     = IDX_W'(cnt_dec - 1'b1);
            mem_raddr = phys_idx(head_nxt, IDX_W'(cnt_dec - 1'b1));
          end
        end
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = phys_idx(head_r, k_r + 1'b1);
        if (walk_stop) begin
          mem_wdata = new_r;
          count_nxt = count_r + 1'b1;
        end else begin
          // shift this entry one slot toward the tail, read the next one up
          mem_wdata = mem_rdata;
          if (k_r != '0) begin
            k_nxt     = k_r - 1'b1;
            mem_raddr = phys_idx(head_r, k_r - 1'b1);
          end
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = new_r;
        count_nxt = count_r + 1'b1;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    new_r    <= new_nxt;
    status_r <= status_nxt;
    ran_r    <= ran_nxt;
  end

  assign res_data.status      = status_r;
  assign res_data.ran_id      = ran_r;
  assign res_data.queue_count = 5'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CNT_W'(k_r) < count_r && count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insertion walk outside the occupied range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !accept) |=> $stable(count_r))
    else $error("queue count moved while idle");

endmodule

/* hdl/dynamic_priority_scheduler.sv */
// top level: priority ready queue controller with a registered result stage
`timescale 1ns / 1ps
// Priority scheduler with aging. The input channel (in_valid/in_ready/in_data)
// takes one request per beat: an add request inserts a task behind every
// queued task of equal or higher priority; a tick pops the head task, lowers
// its remaining ticks and its priority (saturating at -128) and requeues it
// if ticks remain. Every request yields exactly one result beat on the
// output channel (out_valid/out_ready/out_data): status, id of the task that
// ran, and the queue occupancy after the request.
// Steps: rejected requests and adds into an empty queue go straight to the
// result; a tick first pops the head and requeues a task with ticks left,
// into an empty queue directly, else by the insertion walk (tail toward
// head), which writes the task behind the first entry of equal or higher
// priority, or at the head. The walk does one ram read and one ram write
// per cycle; one request is worked on at a time and the next is taken in
// the cycle after the previous result reaches the output register.
// Reset empties the queue; the ram contents need no clearing. A stalled
// receiver holds the result register; the next request is still accepted
// and worked on, and its result waits until the register frees up.
module dynamic_priority_scheduler
  import dps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  dps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
